FILE: hdl/gre_pkg.sv
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types and constants of the graph reachability engine.
// ----------------------------------------------------------------------------
package gre_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ADDR_W       = 3;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] MAX_COUNT          = CNT_W'(MAX_VERTICES);

    // Register indexes on the configuration port.
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // Request kinds.
    localparam logic KIND_ADD_EDGE = 1'b0;
    localparam logic KIND_QUERY    = 1'b1;

    typedef logic [MAX_VERTICES-1:0] row_t;

    typedef struct packed {
        logic             kind;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } gre_req_t;

    typedef struct packed {
        logic reachable;
        logic bad_vertex;
    } gre_rsp_t;

    typedef struct packed {
        logic             rd_en;
        logic [VTX_W-1:0] rd_addr;
        logic             wr_en;
        logic [VTX_W-1:0] wr_addr;
        row_t             wr_data;
    } mem_cmd_t;

endpackage

FILE: hdl/gre_adj_ram.sv
// ----------------------------------------------------------------------------
// gre_adj_ram
// Adjacency matrix store: one row per vertex, one read and one write port,
// registered read data, and a valid bit per row so that reset empties it.
// ----------------------------------------------------------------------------
module gre_adj_ram
    import gre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_cmd_t cmd,
    output row_t     rd_data
);

    row_t                    mem [MAX_VERTICES];
    row_t                    rd_row_reg;
    logic                    rd_valid_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg;

    // A read and a write to the same row in one cycle return the old row.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[cmd.rd_addr];
            end
            if (cmd.wr_en)
            begin
                row_valid_reg[cmd.wr_addr] <= 1'b1;
            end
        end
    end

    // A row never written since reset holds no edges.
    assign rd_data = rd_valid_reg ? rd_row_reg : '0;

endmodule

FILE: hdl/gre_pick.sv
// ----------------------------------------------------------------------------
// gre_pick
// Finds the lowest numbered vertex in a frontier set.
// ----------------------------------------------------------------------------
module gre_pick
    import gre_pkg::*;
(
    input  row_t             set,
    output logic             any,
    output logic [VTX_W-1:0] index
);

    always_comb
    begin
        index = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (set[i])
            begin
                index = VTX_W'(i);
            end
        end
    end

    assign any = |set;

endmodule

FILE: hdl/graph_reachability_engine.sv
// ----------------------------------------------------------------------------
// graph_reachability_engine
// Keeps an undirected graph as an adjacency bit matrix and answers whether
// one vertex can be reached from another.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req_data) takes one word at a
// time: kind 0 adds an undirected edge, kind 1 asks whether vertex_b can be
// reached from vertex_a. Only a query returns a word on the response channel
// (rsp_valid, rsp_ready, rsp_data). An edge with an endpoint at or above the
// vertex count is dropped, and a query with such a vertex answers with
// bad_vertex set and reachable clear.
// An edge is accepted, then each of its two rows gets a read-modify-write.
// A query is accepted, then takes vertices off the frontier one by one and
// reads each one's row (at most the vertex count, fewer when the
// destination shows up early), merges the last row read and loads the
// response register. The search pace is set by the memory read port, which
// delivers one adjacency row per cycle. A query with a bad vertex goes
// straight from the accept to the response register. Requests are accepted
// only between items. After reset the graph is empty and vertex_count is
// 64; no clearing pass is needed. A stalled response holds its word, the
// block may accept and finish an edge meanwhile, and a finished query waits
// until the response register is free. The user is to write vertex_count
// over the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module graph_reachability_engine
    import gre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_ready,
    input  gre_req_t          req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output gre_rsp_t          rsp_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EWA  = 3'd1;
    localparam logic [2:0] S_EWB  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] vertex_count_reg;
    logic [VTX_W-1:0] va_reg, va_next;
    logic [VTX_W-1:0] vb_reg, vb_next;
    row_t             visited_reg, visited_next;
    row_t             frontier_reg, frontier_next;
    logic             rd_pending_reg, rd_pending_next;
    logic             res_reach_reg, res_reach_next;
    logic             res_bad_reg, res_bad_next;
    logic             rsp_valid_reg, rsp_valid_next;
    gre_rsp_t         rsp_data_reg, rsp_data_next;

    logic [CNT_W-1:0] count;
    row_t             active_mask;
    logic             req_ok;
    logic             cfg_write;
    mem_cmd_t         cmd;
    row_t             rd_data;
    row_t             fresh;
    row_t             visited_eff;
    row_t             frontier_eff;
    logic             pick_any;
    logic [VTX_W-1:0] pick_idx;
    logic             hit;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            vertex_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT)
                    ? {{(32-CNT_W){1'b0}}, vertex_count_reg} : 32'd0;

    // ---------------- active vertex set ----------------
    assign count = (vertex_count_reg > MAX_COUNT) ? MAX_COUNT : vertex_count_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            active_mask[i] = (CNT_W'(i) < count);
        end
    end

    assign req_ok = ({1'b0, req_data.vertex_a} < count)
                    && ({1'b0, req_data.vertex_b} < count);

    // ---------------- adjacency store and frontier pick ----------------
    gre_adj_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    // The row read last cycle is merged first, so a pick can follow each cycle.
    assign fresh        = rd_pending_reg ? (rd_data & active_mask & ~visited_reg) : '0;
    assign visited_eff  = visited_reg | fresh;
    assign frontier_eff = frontier_reg | fresh;
    assign hit          = visited_eff[vb_reg];

    gre_pick u_pick
    (
        .set   (frontier_eff),
        .any   (pick_any),
        .index (pick_idx)
    );

    // ---------------- control ----------------
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        visited_next    = visited_reg;
        frontier_next   = frontier_reg;
        rd_pending_next = 1'b0;
        res_reach_next  = res_reach_reg;
        res_bad_next    = res_bad_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        cmd             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    va_next = req_data.vertex_a;
                    vb_next = req_data.vertex_b;
                    if (req_data.kind == KIND_ADD_EDGE)
                    begin
                        if (req_ok)
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = req_data.vertex_a;
                            state_next  = S_EWA;
                        end
                    end
                    else if (!req_ok)
                    begin
                        res_reach_next = 1'b0;
                        res_bad_next   = 1'b1;
                        state_next     = S_PUT;
                    end
                    else
                    begin
                        visited_next  = row_t'(1) << req_data.vertex_a;
                        frontier_next = row_t'(1) << req_data.vertex_a;
                        state_next    = S_RUN;
                    end
                end
            end
            S_EWA:
            begin
                // When both endpoints match, the second pass sets the same bit.
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = va_reg;
                cmd.wr_data = rd_data | (row_t'(1) << vb_reg);
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = vb_reg;
                state_next  = S_EWB;
            end
            S_EWB:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = vb_reg;
                cmd.wr_data = rd_data | (row_t'(1) << va_reg);
                state_next  = S_IDLE;
            end
            S_RUN:
            begin
                visited_next = visited_eff;
                if (hit || !pick_any)
                begin
                    res_reach_next = hit;
                    res_bad_next   = 1'b0;
                    frontier_next  = frontier_eff;
                    state_next     = S_PUT;
                end
                else
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr     = pick_idx;
                    frontier_next   = frontier_eff & ~(row_t'(1) << pick_idx);
                    rd_pending_next = 1'b1;
                end
            end
            S_PUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_data_next.reachable  = res_reach_reg;
                    rsp_data_next.bad_vertex = res_bad_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_pending_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_pending_reg <= rd_pending_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        visited_reg   <= visited_next;
        frontier_reg  <= frontier_next;
        res_reach_reg <= res_reach_next;
        res_bad_reg   <= res_bad_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ---------------- assertions ----------------
    a_src_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> visited_reg[va_reg])
        else $error("source vertex missing from visited set");

    a_frontier_in_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> ((frontier_reg & ~visited_reg) == '0))
        else $error("frontier holds an unvisited vertex");

    a_write_only_edge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == S_EWA || state_reg == S_EWB))
        else $error("adjacency write outside an edge update");

    a_pending_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> ($past(cmd.rd_en) && $past(state_reg) == S_RUN))
        else $error("row merge without a preceding read");

    a_bad_not_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.bad_vertex) |-> !rsp_data_reg.reachable)
        else $error("bad query reported as reachable");

endmodule

FILE: tb/graph_reachability_engine_tb.sv
// ----------------------------------------------------------------------------
// graph_reachability_engine_tb
// Drives edge and query words into the reachability engine and checks every
// answer against a bit-matrix search in the bench or a fixed table value. A
// short table covers the corner cases first. Random phases at several
// vertex counts follow, with random idling on both channels in all but one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_reachability_engine_tb;
    import gre_pkg::*;

    localparam int PLAN_ROWS     = 30;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 205;
    localparam int CALM_PHASE    = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SPARE_REG     = 1;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_SET_COUNT,
        ROW_SPARE_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t        what;
        gre_req_t         word;
        logic             typed;
        gre_rsp_t         want;
        logic [CNT_W-1:0] count;
    } plan_row_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              req_valid = 1'b0;
    logic              req_ready;
    gre_req_t          req_data  = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    gre_rsp_t          rsp_data;

    // Bench copy of the graph and of the vertex count register.
    row_t              graph_rows [MAX_VERTICES];
    logic [CNT_W-1:0]  count_reg = VERTEX_COUNT_RESET;
    gre_rsp_t          answers_due [$];

    int                errors       = 0;
    int                quiet_cycles = 0;
    int                hold_left    = 0;
    logic              calm         = 1'b0;

    graph_reachability_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    function automatic plan_row_t plan_query(input int a, input int b);
        plan_row_t r;
        r = '0;
        r.what = ROW_WORD;
        r.word = '{KIND_QUERY, VTX_W'(a), VTX_W'(b)};
        return r;
    endfunction

    function automatic plan_row_t plan_query_known(input int a, input int b,
                                                   input logic hit, input logic bad);
        plan_row_t r;
        r = plan_query(a, b);
        r.typed = 1'b1;
        r.want = '{hit, bad};
        return r;
    endfunction

    function automatic plan_row_t plan_edge(input int a, input int b);
        plan_row_t r;
        r = '0;
        r.what = ROW_WORD;
        r.word = '{KIND_ADD_EDGE, VTX_W'(a), VTX_W'(b)};
        return r;
    endfunction

    function automatic plan_row_t plan_count(input int n);
        plan_row_t r;
        r = '0;
        r.what = ROW_SET_COUNT;
        r.count = CNT_W'(n);
        return r;
    endfunction

    plan_row_t plan [PLAN_ROWS] = '{
        plan_query_known(0, 0, 1'b1, 1'b0),
        plan_query_known(0, 63, 1'b0, 1'b0),
        plan_query_known(63, 63, 1'b1, 1'b0),
        plan_edge(0, 63),
        plan_query(63, 0),
        plan_edge(5, 5),
        plan_query(5, 6),
        plan_edge(63, 0),
        plan_edge(10, 11),
        plan_edge(11, 12),
        plan_edge(12, 63),
        plan_query(10, 0),
        plan_edge(21, 42),
        plan_query(42, 21),
        plan_count(32),
        plan_query_known(40, 0, 1'b0, 1'b1),
        plan_query_known(0, 40, 1'b0, 1'b1),
        plan_edge(33, 1),
        plan_query(10, 0),
        plan_count(0),
        plan_query_known(0, 0, 1'b0, 1'b1),
        plan_edge(0, 1),
        plan_count(127),
        plan_query(10, 0),
        '{ROW_SPARE_WRITE, '0, 1'b0, '0, '0},
        plan_count(1),
        plan_query_known(0, 0, 1'b1, 1'b0),
        plan_query_known(0, 1, 1'b0, 1'b1),
        plan_count(64),
        plan_query(1, 0)
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_count();
        return (count_reg > MAX_COUNT) ? MAX_VERTICES : int'(count_reg);
    endfunction

    // Grows the set of vertices seen from the source one hop per pass, only
    // through vertices below the active count, until nothing new turns up.
    function automatic gre_rsp_t reach_answer(input gre_req_t w);
        gre_rsp_t ans;
        row_t     live;
        row_t     seen;
        row_t     wave;
        row_t     grow;
        int       n;
        n = active_count();
        ans = '0;
        if (int'(w.vertex_a) >= n || int'(w.vertex_b) >= n)
        begin
            ans.bad_vertex = 1'b1;
            return ans;
        end
        for (int v = 0; v < MAX_VERTICES; v++)
            live[v] = (v < n);
        seen = '0;
        seen[w.vertex_a] = 1'b1;
        wave = seen;
        while (wave != '0)
        begin
            grow = '0;
            for (int v = 0; v < MAX_VERTICES; v++)
                if (wave[v])
                    grow |= graph_rows[v];
            grow &= live & ~seen;
            seen |= grow;
            wave = grow;
        end
        ans.reachable = seen[w.vertex_b];
        return ans;
    endfunction

    function automatic gre_req_t pick_word(input bit cross_ok);
        gre_req_t w;
        int       n;
        int       roll;
        int       a;
        n = active_count();
        roll = $urandom_range(99);
        a = $urandom_range(n - 1);
        w.kind = KIND_QUERY;
        w.vertex_a = VTX_W'(a);
        w.vertex_b = VTX_W'($urandom_range(n - 1));
        if (roll < 25)
        begin
            w.kind = KIND_ADD_EDGE;
            // Edges mostly stay inside one residue class mod 4, so the graph
            // forms four long chains rather than one blob, and answers vary.
            if (!cross_ok || roll >= 6)
                w.vertex_b = VTX_W'((a + 4 * $urandom_range(3, 1)) % MAX_VERTICES);
        end
        else if (roll < 29)
        begin
            w.kind = KIND_ADD_EDGE;
            w.vertex_a = VTX_W'($urandom_range(MAX_VERTICES - 1));
            w.vertex_b = {4'($urandom_range(15)), w.vertex_a[1:0]};
            if (roll == 25)
                w.vertex_b = w.vertex_a;
        end
        else if (roll < 36)
        begin
            w.vertex_a = VTX_W'($urandom_range(MAX_VERTICES - 1));
            w.vertex_b = VTX_W'($urandom_range(MAX_VERTICES - 1));
        end
        return w;
    endfunction

    // Offers one word, holds it until taken, then updates the bench graph or
    // queues the answer that the word should produce.
    task automatic send_word(input gre_req_t w, input logic typed, input gre_rsp_t want);
        int gap;
        int n;
        gap = 0;
        if (!calm)
        begin
            if ($urandom_range(999) < 4)
                gap = $urandom_range(90, 10);
            while ($urandom_range(99) < 22)
                gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= w;
        do @(posedge clk); while (!req_ready);
        n = active_count();
        if (w.kind == KIND_QUERY)
            answers_due.insert(answers_due.size(), typed ? want : reach_answer(w));
        else if (int'(w.vertex_a) < n && int'(w.vertex_b) < n)
        begin
            graph_rows[w.vertex_a][w.vertex_b] = 1'b1;
            graph_rows[w.vertex_b][w.vertex_a] = 1'b1;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == int'(REG_VERTEX_COUNT))
            count_reg = value[CNT_W-1:0];
        @(posedge clk);
    endtask

    // Reads the vertex count back and compares it with the bench copy.
    task automatic check_count_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(REG_VERTEX_COUNT) * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(count_reg))
        begin
            $display("%0t: vertex_count readback expected %0d got %0d",
                     $time, count_reg, got);
            errors++;
        end
        @(posedge clk);
    endtask

    task automatic set_vertex_count(input int n);
        logic [31:0] value;
        value = $urandom();
        value[CNT_W-1:0] = CNT_W'(n);
        drain();
        reg_write(int'(REG_VERTEX_COUNT), value);
        check_count_readback();
    endtask

    initial
    begin
        gre_rsp_t none;
        none = '0;
        for (int v = 0; v < MAX_VERTICES; v++)
            graph_rows[v] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            case (plan[i].what)
                ROW_WORD:
                    send_word(plan[i].word, plan[i].typed, plan[i].want);
                ROW_SET_COUNT:
                    set_vertex_count(int'(plan[i].count));
                default:
                begin
                    // A write past the register list must leave the count alone.
                    drain();
                    reg_write(SPARE_REG, $urandom());
                    check_count_readback();
                end
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_vertex_count(64);
                1:       set_vertex_count(45);
                2:       set_vertex_count(17);
                4:       set_vertex_count(2);
                5:       set_vertex_count(100);
                6:       set_vertex_count(30);
                default: set_vertex_count(64);
            endcase
            calm <= (p == CALM_PHASE);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_word(pick_word(p == PHASES - 1), 1'b0, none);
        end

        drain();
        if (errors == 0)
            $display("graph_reachability_engine_tb OK");
        else
            $display("graph_reachability_engine_tb NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (calm)
        begin
            rsp_ready <= 1'b1;
        end
        else if ($urandom_range(999) < 4)
        begin
            hold_left <= $urandom_range(90, 10);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin : check_answer
        gre_rsp_t due;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected answer word reachable=%0d bad_vertex=%0d",
                         $time, rsp_data.reachable, rsp_data.bad_vertex);
                errors++;
            end
            else
            begin
                due = answers_due.pop_front();
                if (rsp_data.reachable !== due.reachable)
                begin
                    $display("%0t: reachable expected %0d got %0d",
                             $time, due.reachable, rsp_data.reachable);
                    errors++;
                end
                if (rsp_data.bad_vertex !== due.bad_vertex)
                begin
                    $display("%0t: bad_vertex expected %0d got %0d",
                             $time, due.bad_vertex, rsp_data.bad_vertex);
                    errors++;
                end
            end
        end
    end

    // Ends the run if no word moves on any port for too long.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("graph_reachability_engine_tb NOT OK");
            $finish;
        end
    end

endmodule

FILE: files.f
hdl/gre_pkg.sv
hdl/gre_adj_ram.sv
hdl/gre_pick.sv
hdl/graph_reachability_engine.sv
tb/graph_reachability_engine_tb.sv
